// ===== hw/rtl/pse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
`timescale 1ns / 1ps

package pse_pkg;

    localparam int WORD_W          = 32;
    localparam int DEF_STACK_DEPTH = 16;

    // ASCII codes of the accepted characters
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_MUL   = 8'h2A;
    localparam logic [7:0] SYM_DIV   = 8'h2F;
    localparam logic [7:0] SYM_POW   = 8'h24;
    localparam logic [7:0] SYM_ZERO  = 8'h30;
    localparam logic [7:0] SYM_NINE  = 8'h39;

    // arithmetic unit operations
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic              start;
        logic [2:0]        op;
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic              dz;
        logic [WORD_W-1:0] value;
    } t_alu_rsp;

endpackage

// ===== hw/rtl/pse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/pse_alu.sv =====
// Iterative arithmetic unit: add, sub, multiply, restoring divide,
// square-and-multiply power on one shared multiplier.
`timescale 1ns / 1ps

module pse_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pse_pkg::t_alu_req  i_req,
    output pse_pkg::t_alu_rsp  o_rsp
);

    import pse_pkg::*;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_DIV  = 3'd2;
    localparam logic [2:0] A_FIX  = 3'd3;
    localparam logic [2:0] A_POW  = 3'd4;

    localparam logic [4:0] DIV_LAST = 5'd31;
    localparam logic [4:0] POW_LAST = 5'd30;

    logic [2:0]        r_state;
    logic [4:0]        r_cnt;
    logic              r_phase;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_sq;
    logic [WORD_W-1:0] r_ex;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_den;
    logic              r_neg;
    logic              r_done;
    logic              r_dz;
    logic [WORD_W-1:0] r_res;

    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] prod;
    logic [WORD_W:0]   div_sh;
    logic [WORD_W:0]   div_diff;
    logic              div_ge;
    logic [WORD_W-1:0] mag_l;
    logic [WORD_W-1:0] mag_r;

    // shared multiplier, low word only
    assign mul_a = (r_state == A_POW && r_phase) ? r_sq : r_acc;
    assign prod  = mul_a * r_sq;

    assign div_sh   = {r_rem, r_quo[WORD_W-1]};
    assign div_diff = div_sh - {1'b0, r_den};
    assign div_ge   = div_sh >= {1'b0, r_den};

    assign mag_l = i_req.lhs[WORD_W-1] ? (~i_req.lhs + 1'b1) : i_req.lhs;
    assign mag_r = i_req.rhs[WORD_W-1] ? (~i_req.rhs + 1'b1) : i_req.rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_dz    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_dz   <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        case (i_req.op)
                            OP_ADD: begin
                                r_res  <= i_req.lhs + i_req.rhs;
                                r_done <= 1'b1;
                            end
                            OP_SUB: begin
                                r_res  <= i_req.lhs - i_req.rhs;
                                r_done <= 1'b1;
                            end
                            OP_MUL: begin
                                r_acc   <= i_req.lhs;
                                r_sq    <= i_req.rhs;
                                r_state <= A_MUL;
                            end
                            OP_DIV: begin
                                if (i_req.rhs == '0) begin
                                    r_res  <= '0;
                                    r_dz   <= 1'b1;
                                    r_done <= 1'b1;
                                end else begin
                                    r_rem   <= '0;
                                    r_quo   <= mag_l;
                                    r_den   <= mag_r;
                                    r_neg   <= i_req.lhs[WORD_W-1] ^ i_req.rhs[WORD_W-1];
                                    r_cnt   <= '0;
                                    r_state <= A_DIV;
                                end
                            end
                            OP_POW: begin
                                if (i_req.rhs[WORD_W-1]) begin
                                    // negative exponent: reciprocal truncated
                                    r_done <= 1'b1;
                                    if (i_req.lhs == WORD_W'(1)) begin
                                        r_res <= WORD_W'(1);
                                    end else if (i_req.lhs == '1) begin
                                        r_res <= i_req.rhs[0] ? '1 : WORD_W'(1);
                                    end else begin
                                        r_res <= '0;
                                        r_dz  <= (i_req.lhs == '0);
                                    end
                                end else begin
                                    r_acc   <= WORD_W'(1);
                                    r_sq    <= i_req.lhs;
                                    r_ex    <= i_req.rhs;
                                    r_cnt   <= '0;
                                    r_phase <= 1'b0;
                                    r_state <= A_POW;
                                end
                            end
                            default: begin
                                r_res  <= '0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    r_res   <= prod;
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DIV: begin
                    r_rem <= div_ge ? div_diff[WORD_W-1:0] : div_sh[WORD_W-1:0];
                    r_quo <= {r_quo[WORD_W-2:0], div_ge};
                    if (r_cnt == DIV_LAST) begin
                        r_state <= A_FIX;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                A_FIX: begin
                    r_res   <= r_neg ? (~r_quo + 1'b1) : r_quo;
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_POW: begin
                    if (!r_phase) begin
                        if (r_ex[0]) begin
                            r_acc <= prod;
                        end
                        r_phase <= 1'b1;
                    end else begin
                        r_sq    <= prod;
                        r_ex    <= r_ex >> 1;
                        r_phase <= 1'b0;
                        if (r_cnt == POW_LAST) begin
                            r_res   <= r_acc;
                            r_done  <= 1'b1;
                            r_state <= A_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.dz    = r_dz;
    assign o_rsp.value = r_res;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) != A_IDLE || $past(i_req.start))
        else $error("alu done without a request");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dz |-> r_done && r_res == '0)
        else $error("alu zero-divide flag without zero result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == A_DIV |-> r_den != '0)
        else $error("alu dividing by zero");

endmodule

// ===== hw/rtl/postfix_stack_evaluator_top.sv =====
// A digit is pushed; an operator pops two operands, runs the unit (power on the
// shared multiplier) and pushes the result; the last word then pops the result.
// Words are taken one at a time; ready only in idle.
// Result is held in an output register until taken; the next result waits for it.
// Reset (synchronous, active low) empties the stack and clears all flags;
// stack RAM contents are not cleared.
`timescale 1ns / 1ps

module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_symbol,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [pse_pkg::WORD_W-1:0] o_value,
    output logic [1:0]                        o_status
);

    import pse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_POPC = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;

    localparam logic [1:0] POP_R = 2'd0;
    localparam logic [1:0] POP_L = 2'd1;
    localparam logic [1:0] POP_F = 2'd2;

    logic [2:0]        r_state;
    logic [1:0]        r_pop_phase;
    logic              r_pop_empty;
    logic [CW-1:0]     r_count;
    logic              r_ovf;
    logic              r_dz;
    logic              r_abort;
    logic              r_last;
    logic [2:0]        r_op;
    logic [WORD_W-1:0] r_opr;
    logic [WORD_W-1:0] r_opl;
    logic [WORD_W-1:0] r_res;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_value;
    logic [1:0]        r_out_status;

    logic              accept;
    logic              full;
    logic              is_digit;
    logic              is_op;
    logic [2:0]        sym_op;
    logic [CW-1:0]     cnt_m1;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] pop_val;
    logic [7:0]        digit;
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign cnt_m1   = r_count - 1'b1;
    assign ram_we   = (r_state == S_PUSH) && !full;
    assign pop_val  = r_pop_empty ? '1 : ram_rdata;
    assign is_digit = (i_symbol >= SYM_ZERO) && (i_symbol <= SYM_NINE);
    assign digit    = i_symbol - SYM_ZERO;

    always_comb begin
        is_op  = 1'b1;
        sym_op = OP_ADD;
        case (i_symbol)
            SYM_PLUS:  sym_op = OP_ADD;
            SYM_MINUS: sym_op = OP_SUB;
            SYM_MUL:   sym_op = OP_MUL;
            SYM_DIV:   sym_op = OP_DIV;
            SYM_POW:   sym_op = OP_POW;
            default:   is_op  = 1'b0;
        endcase
    end

    pse_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_res),
        .i_raddr(cnt_m1[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign alu_req.start = (r_state == S_EXEC);
    assign alu_req.op    = r_op;
    assign alu_req.lhs   = r_opl;
    assign alu_req.rhs   = r_opr;

    pse_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pop_phase <= POP_R;
            r_pop_empty <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_dz        <= 1'b0;
            r_abort     <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_last;
                        if (r_abort) begin
                            // skip words up to the last one
                            if (i_last) begin
                                r_state <= S_RES;
                            end
                        end else if (is_digit) begin
                            r_res   <= {{(WORD_W-8){1'b0}}, digit};
                            r_state <= S_PUSH;
                        end else if (is_op) begin
                            r_op        <= sym_op;
                            r_pop_phase <= POP_R;
                            r_state     <= S_POP;
                        end else begin
                            r_abort <= 1'b1;
                            if (i_last) begin
                                r_state <= S_RES;
                            end
                        end
                    end
                end
                S_POP: begin
                    // RAM read of top entry is issued this cycle
                    if (r_count == '0) begin
                        r_pop_empty <= 1'b1;
                    end else begin
                        r_pop_empty <= 1'b0;
                        r_count     <= cnt_m1;
                    end
                    r_state <= S_POPC;
                end
                S_POPC: begin
                    case (r_pop_phase)
                        POP_R: begin
                            r_opr       <= pop_val;
                            r_pop_phase <= POP_L;
                            r_state     <= S_POP;
                        end
                        POP_L: begin
                            r_opl   <= pop_val;
                            r_state <= S_EXEC;
                        end
                        default: begin
                            r_res   <= pop_val;
                            r_state <= S_RES;
                        end
                    endcase
                end
                S_EXEC: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        r_res <= alu_rsp.value;
                        if (alu_rsp.dz) begin
                            r_dz <= 1'b1;
                        end
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                    if (r_last) begin
                        r_pop_phase <= POP_F;
                        r_state     <= S_POP;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RES: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        if (r_abort) begin
                            r_out_value  <= '0;
                            r_out_status <= ST_ILLEGAL;
                        end else begin
                            r_out_value <= r_res;
                            if (r_dz) begin
                                r_out_status <= ST_DIVZERO;
                            end else if (r_ovf) begin
                                r_out_status <= ST_OVERFLOW;
                            end else begin
                                r_out_status <= ST_OK;
                            end
                        end
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_dz    <= 1'b0;
                        r_abort <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_RES)
        else $error("result word raised outside result state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> r_state == S_WAIT)
        else $error("alu done while not waiting");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RES && (!r_out_valid || i_ready) |=> r_count == '0 && !r_abort)
        else $error("state not cleared after result");

endmodule
